@@ src/aeske_pkg.sv @@
// Package for the AES-256 key expansion: item types, state codes, S-box and constants.
`default_nettype none

package aeske_pkg;

  localparam int unsigned KeyWords   = 8;
  localparam int unsigned SchedWords = 60;
  localparam int unsigned IdxW       = 6;

  localparam logic [IdxW-1:0] LastIdx   = IdxW'(SchedWords - 1);
  localparam logic [7:0]      RconFirst = 8'h01;
  localparam logic [7:0]      RconPoly  = 8'h1b;

  // One key, most significant key byte first
  typedef struct packed {
    logic [63:0] key_bytes_0_to_7;
    logic [63:0] key_bytes_8_to_15;
    logic [63:0] key_bytes_16_to_23;
    logic [63:0] key_bytes_24_to_31;
  } key_item_t;

  // One schedule word
  typedef struct packed {
    logic [IdxW-1:0] word_index;
    logic [31:0]     round_key_word;
    logic            last_word;
  } word_item_t;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Substitute every byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Double in GF(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    gf_double = {b[6:0], 1'b0} ^ (b[7] ? RconPoly : 8'h00);
  endfunction

endpackage

`default_nettype wire

@@ src/aes256_key_expansion.sv @@
// AES-256 key expansion: one key in, the 60 schedule words out in order.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one 256-bit key
// as four 64-bit parts, key byte 0 most significant. Output channel
// (out_valid_o / out_ready_i / out_data_o) delivers 60 items per key: the
// word index, the 32-bit schedule word and a flag set on word 59.
// The first word is registered once the sequencer has entered its run
// state; after that one word per cycle while the receiver takes them.
// in_ready_o is high only while the sequencer is idle.
// The words come from an eight-word shift window and one shared S-box unit
// of four byte lookups that produces one word per cycle.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle; the window needs no clearing, since every key
// loads all eight slots before any is used.
`default_nettype none

module aes256_key_expansion import aeske_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire key_item_t  in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output word_item_t      out_data_o
);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [7:0]      rc_q, rc_d;
  logic [31:0]     win_q [KeyWords];
  logic            out_valid_q, out_valid_d;
  word_item_t      out_q;

  logic        in_acc;
  logic        step;
  logic [31:0] prev_w;
  logic [31:0] sbox_in;
  logic [31:0] sbox_out;
  logic [31:0] temp_w;
  logic [31:0] next_w;
  logic        is_key;
  logic        is_rot;
  logic        is_sub;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Advance one word when running and the output register is free
  assign step = (state_q == StRun) && (!out_valid_q || out_ready_i);

  // Shared S-box unit: rotate first on round boundaries
  assign prev_w   = win_q[KeyWords-1];
  assign is_key   = (cnt_q < IdxW'(KeyWords));
  assign is_rot   = (cnt_q[2:0] == 3'd0);
  assign is_sub   = (cnt_q[2:0] == 3'd4);
  assign sbox_in  = is_rot ? {prev_w[23:0], prev_w[31:24]} : prev_w;
  assign sbox_out = sub_word(sbox_in);

  always_comb begin
    if (is_rot) begin
      temp_w = sbox_out ^ {rc_q, 24'h000000};
    end else if (is_sub) begin
      temp_w = sbox_out;
    end else begin
      temp_w = prev_w;
    end
  end

  // Key words pass through; later words combine with the word eight back
  assign next_w = is_key ? win_q[0] : (win_q[0] ^ temp_w);

  // Sequencer: next state, counter, round constant, output valid
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rc_d        = rc_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRun;
          cnt_d   = '0;
          rc_d    = RconFirst;
        end
      end
      StRun: begin
        if (step) begin
          out_valid_d = 1'b1;
          if (!is_key && is_rot) begin
            rc_d = gf_double(rc_q);
          end
          if (cnt_q == LastIdx) begin
            state_d = StIdle;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rc_q        <= RconFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rc_q        <= rc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window: load the key, then shift in one word per step (oldest at slot 0)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_q[0] <= in_data_i.key_bytes_0_to_7[63:32];
      win_q[1] <= in_data_i.key_bytes_0_to_7[31:0];
      win_q[2] <= in_data_i.key_bytes_8_to_15[63:32];
      win_q[3] <= in_data_i.key_bytes_8_to_15[31:0];
      win_q[4] <= in_data_i.key_bytes_16_to_23[63:32];
      win_q[5] <= in_data_i.key_bytes_16_to_23[31:0];
      win_q[6] <= in_data_i.key_bytes_24_to_31[63:32];
      win_q[7] <= in_data_i.key_bytes_24_to_31[31:0];
    end else if (step) begin
      for (int k = 0; k < KeyWords - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[KeyWords-1] <= next_w;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.word_index     <= cnt_q;
      out_q.round_key_word <= next_w;
      out_q.last_word      <= (cnt_q == LastIdx);
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/aes256_key_schedule_checker.sv @@
// Checker for the AES-256 key expansion: predicts each key's schedule and compares every word.

module aes256_key_schedule_checker import aeske_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       key_valid_i,
  input  logic       key_ready_i,
  input  key_item_t  key_i,
  input  logic       word_valid_i,
  input  logic       word_ready_i,
  input  word_item_t word_i,
  output int         mismatch_count_o,
  output int         words_pending_o,
  output int         words_checked_o
);

  localparam int          ScheduleLen = 60;
  localparam int          WindowLen   = 8;
  localparam logic [7:0]  RconStart   = 8'h01;
  localparam logic [7:0]  FieldPoly   = 8'h1b;
  localparam logic [7:0]  AffineConst = 8'h63;

  logic [7:0] sbox_lut [256];
  word_item_t expected_words [$];
  int         mismatches;
  int         words_checked;

  // Multiply in GF(2^8) with the AES reduction polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    int         k;
    acc = '0;
    x   = a;
    for (k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? FieldPoly : 8'h00);
    end
    return acc;
  endfunction

  // Substitute each byte of a word through the S-box table
  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  // Expand one key and queue its 60 schedule words
  function automatic void queue_schedule(input key_item_t key);
    logic [255:0] flat;
    logic [31:0]  win [WindowLen];
    logic [31:0]  t;
    logic [31:0]  w;
    logic [7:0]   rcon;
    word_item_t   item;
    int           i;
    flat = key;
    rcon = RconStart;
    for (i = 0; i < ScheduleLen; i++) begin
      if (i < WindowLen) begin
        w = flat[255 - 32 * i -: 32];
      end else begin
        t = win[(i - 1) % WindowLen];
        if (i % WindowLen == 0) begin
          t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = gf_mul(rcon, 8'h02);
        end else if (i % WindowLen == 4) begin
          t = subst_word(t);
        end
        w = win[i % WindowLen] ^ t;
      end
      win[i % WindowLen] = w;
      item.word_index     = 6'(i);
      item.round_key_word = w;
      item.last_word      = (i == ScheduleLen - 1);
      expected_words.push_back(item);
    end
  endfunction

  // Count and report a field mismatch
  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  // Build the S-box from the field inverse and the affine map
  initial begin
    logic [7:0] inv;
    logic [7:0] b;
    int         x;
    int         y;
    for (x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      b = inv;
      sbox_lut[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ AffineConst;
    end
  end

  // Compare each accepted word, then queue the schedule of an accepted key
  always @(posedge clk_i) begin
    word_item_t want;
    if (rst_ni) begin
      if (word_valid_i && word_ready_i) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got index %0d word %h last %b",
                   $time, word_i.word_index, word_i.round_key_word, word_i.last_word);
        end else begin
          want = expected_words.pop_front();
          check_field("word_index", 32'(want.word_index), 32'(word_i.word_index));
          check_field("round_key_word", want.round_key_word, word_i.round_key_word);
          check_field("last_word", 32'(want.last_word), 32'(word_i.last_word));
        end
      end
      if (key_valid_i && key_ready_i) queue_schedule(key_i);
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= expected_words.size();
    words_checked_o  <= words_checked;
  end

endmodule

@@ tb/sv/tb_aes256_key_expansion.sv @@
// Testbench top for the AES-256 key expansion: key stimulus, word stalls and the verdict.

module tb_aes256_key_expansion;
  import aeske_pkg::*;

  localparam int RandomKeys   = 410;
  localparam int DrainEvery   = 100;
  localparam int CycleLimit   = 1000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       key_valid = 1'b0;
  logic       key_ready;
  key_item_t  key_data = '0;
  logic       word_valid;
  logic       word_ready = 1'b0;
  word_item_t word_data;

  int          mismatches;
  int          words_pending;
  int          words_checked;
  int          cycle_count = 0;
  logic [31:0] rx_tick = '0;
  int          directed_sent = 0;
  int          random_sent = 0;
  key_item_t   directed_keys [$];

  aes256_key_expansion dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (key_valid),
    .in_ready_o  (key_ready),
    .in_data_i   (key_data),
    .out_valid_o (word_valid),
    .out_ready_i (word_ready),
    .out_data_o  (word_data)
  );

  aes256_key_schedule_checker checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .key_valid_i      (key_valid),
    .key_ready_i      (key_ready),
    .key_i            (key_data),
    .word_valid_i     (word_valid),
    .word_ready_i     (word_ready),
    .word_i           (word_data),
    .mismatch_count_o (mismatches),
    .words_pending_o  (words_pending),
    .words_checked_o  (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the word channel, changing pattern with bits 9:8 of rx_tick
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[9:8])
      2'd0: word_ready <= 1'b1;
      2'd1: word_ready <= 1'($urandom_range(0, 1));
      2'd2: word_ready <= ($urandom_range(0, 3) == 0);
      default: word_ready <= (rx_tick % 7) >= 3;
    endcase
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, CycleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one key and hold it until taken
  task automatic offer_key(input key_item_t key);
    key_valid <= 1'b1;
    key_data  <= key;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
  endtask

  // Drop valid for a gap whose length is given by n
  task automatic idle_for(input int n);
    if (n > 0) begin
      key_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every queued word has come out
  task automatic wait_drained(input int settle);
    key_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Mix full random keys, sparse keys and keys of all-0/all-1 bytes
  function automatic key_item_t random_key();
    logic [255:0] bits;
    int           pick;
    int           j;
    pick = $urandom_range(0, 9);
    bits = '0;
    if (pick < 6) begin
      for (j = 0; j < 8; j++) bits[32 * j +: 32] = $urandom;
    end else if (pick < 8) begin
      repeat ($urandom_range(1, 4)) bits[8 * $urandom_range(0, 31) +: 8] = 8'($urandom);
    end else begin
      for (j = 0; j < 32; j++) bits[8 * j +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end
    return bits;
  endfunction

  initial begin
    int burst;
    int n;
    int next_drain;

    // Zero key first: the window is read only after this key fills it
    directed_keys.push_back('0);
    directed_keys.push_back('1);
    directed_keys.push_back({64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                             64'h1011121314151617, 64'h18191a1b1c1d1e1f});
    directed_keys.push_back({64'h603deb1015ca71be, 64'h2b73aef0857d7781,
                             64'h1f352c073b6108d7, 64'h2d9810a30914dff4});
    directed_keys.push_back({64'hffffffffffffffff, 64'h0, 64'h0, 64'h0});
    directed_keys.push_back({64'h0, 64'hffffffffffffffff, 64'h0, 64'h0});
    directed_keys.push_back({64'h0, 64'h0, 64'hffffffffffffffff, 64'h0});
    directed_keys.push_back({64'h0, 64'h0, 64'h0, 64'hffffffffffffffff});
    directed_keys.push_back({4{64'haaaaaaaaaaaaaaaa}});
    directed_keys.push_back({4{64'h5555555555555555}});
    directed_keys.push_back({64'h8000000000000000, 64'h0, 64'h0, 64'h1});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Send the directed keys back to back so each one restarts the counter
    foreach (directed_keys[k]) begin
      offer_key(directed_keys[k]);
      directed_sent++;
    end
    wait_drained(4);

    // Random keys in bursts, draining fully now and then
    next_drain = DrainEvery;
    while (random_sent < RandomKeys) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      for (n = 0; n < burst && random_sent < RandomKeys; n++) begin
        offer_key(random_key());
        random_sent++;
      end
      if (random_sent >= next_drain) begin
        wait_drained(4);
        next_drain += DrainEvery;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 40));
      end
    end

    wait_drained(20);

    $display("covered %0d keys (%0d directed, %0d random) under shifting word stalls",
             directed_sent + random_sent, directed_sent, random_sent);
    $display("checked %0d schedule words, %0d still waiting, %0d mismatches",
             words_checked, words_pending, mismatches);
    if (mismatches == 0 && words_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/aeske_pkg.sv
src/aes256_key_expansion.sv
tb/sv/aes256_key_schedule_checker.sv
tb/sv/tb_aes256_key_expansion.sv
